// ===== design/ilst_pkg.sv =====
package ilst_pkg;

    // Sizes of the list and of one stored word.
    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int REQ_W      = 3;

    // Stream packing of the input word (tdata) and of the result word.
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 80;
    localparam int S_IDX_LO   = 0;
    localparam int S_END_LO   = S_IDX_LO + IDX_W;
    localparam int S_VAL_LO   = S_END_LO + IDX_W;
    localparam int M_RD_LO    = 0;
    localparam int M_STAT_LO  = M_RD_LO + VALUE_W;
    localparam int M_CNT_LO   = M_STAT_LO + STATUS_W;
    localparam int M_USED_W   = M_CNT_LO + CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 3'd0,
        REQ_READ      = 3'd1,
        REQ_WRITE     = 3'd2,
        REQ_ERASE     = 3'd3,
        REQ_ERASE_RNG = 3'd4,
        REQ_POP       = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_IDX  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic                  shift_en;
        logic [IDX_W-1:0]      shift_base;
        logic                  wr_en;
        logic [IDX_W-1:0]      wr_idx;
        logic [DATA_WIDTH-1:0] wr_data;
    } cell_ctrl_t;

endpackage

// ===== design/indexed_list_store_core.sv =====
// Except for an erase range of several entries, an accepted word shows its
// result in the next cycle, and a new word is taken once the output is free.
// An erase range of several entries holds off new words in the shift state,
// as the cell chain moves entries down by one position per cycle.
// Reset clears the fill count and the handshake state; stored entries are
// not cleared and only positions below the count are ever read.
module indexed_list_store_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // index [5:0], end_index [11:6], value [75:12], zero fill above
    input  logic [ilst_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type [2:0]
    input  logic [ilst_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_value [63:0], status [65:64], count [72:66], zero fill above
    output logic [ilst_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int DW = ilst_pkg::DATA_WIDTH;
    localparam int IW = ilst_pkg::IDX_W;
    localparam int CW = ilst_pkg::CNT_W;
    localparam int VW = ilst_pkg::VALUE_W;

    ilst_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      base_reg, base_next;
    logic [IW-1:0]      remain_reg, remain_next;
    logic               m_valid_reg, m_valid_next;
    logic [VW-1:0]      rd_reg, rd_next;
    ilst_pkg::status_t  status_reg, status_next;
    logic [CW-1:0]      out_cnt_reg, out_cnt_next;

    ilst_pkg::cell_ctrl_t ctrl;
    logic [DW-1:0]        cell_data [ilst_pkg::CAPACITY];

    logic [IW-1:0] in_idx;
    logic [IW-1:0] in_end;
    logic [DW-1:0] in_word;
    logic [CW-1:0] count_m1;
    logic [IW-1:0] rd_idx;
    logic [DW-1:0] rd_word;
    logic          out_free;
    logic          accept;
    logic          idx_ok;

    assign in_idx   = s_tdata[ilst_pkg::S_IDX_LO +: IW];
    assign in_end   = s_tdata[ilst_pkg::S_END_LO +: IW];
    assign in_word  = s_tdata[ilst_pkg::S_VAL_LO +: DW];
    assign count_m1 = count_reg - CW'(1);
    assign idx_ok   = {1'b0, in_idx} < count_reg;

    // Read port: the addressed cell, or the top entry for a pop.
    assign rd_idx  = (s_tuser == ilst_pkg::REQ_POP) ? count_m1[IW-1:0] : in_idx;
    assign rd_word = cell_data[rd_idx];

    // Handshake: one word at a time, output register freed or draining.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ilst_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Cell chain: each cell pulls from its upper neighbor, the top one pulls zero.
    for (genvar i = 0; i < ilst_pkg::CAPACITY; i++) begin : g_cell
        logic [DW-1:0] up_data;
        if (i == ilst_pkg::CAPACITY - 1) begin : g_top
            assign up_data = '0;
        end else begin : g_mid
            assign up_data = cell_data[i+1];
        end
        ilst_cell u_cell (
            .aclk      (aclk),
            .ctrl_i    (ctrl),
            .pos_i     (IW'(i)),
            .up_data_i (up_data),
            .data_o    (cell_data[i])
        );
    end

    // Request decode, erase sequencing and result formation.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        remain_next  = remain_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_next      = rd_reg;
        status_next  = status_reg;
        out_cnt_next = out_cnt_reg;
        ctrl         = '0;
        ctrl.wr_data = in_word;

        unique case (state_reg)
            ilst_pkg::ST_IDLE: begin
                if (accept) begin
                    rd_next      = '0;
                    status_next  = ilst_pkg::STAT_OK;
                    m_valid_next = 1'b1;
                    case (s_tuser)
                        ilst_pkg::REQ_APPEND: begin
                            if (count_reg == CW'(ilst_pkg::CAPACITY)) begin
                                status_next = ilst_pkg::STAT_FULL;
                            end else begin
                                ctrl.wr_en  = 1'b1;
                                ctrl.wr_idx = count_reg[IW-1:0];
                                count_next  = count_reg + CW'(1);
                            end
                        end
                        ilst_pkg::REQ_READ: begin
                            if (idx_ok) begin
                                rd_next = VW'($signed(rd_word));
                            end else begin
                                status_next = ilst_pkg::STAT_IDX;
                            end
                        end
                        ilst_pkg::REQ_WRITE: begin
                            if (idx_ok) begin
                                ctrl.wr_en  = 1'b1;
                                ctrl.wr_idx = in_idx;
                            end else begin
                                status_next = ilst_pkg::STAT_IDX;
                            end
                        end
                        ilst_pkg::REQ_ERASE: begin
                            if (idx_ok) begin
                                ctrl.shift_en   = 1'b1;
                                ctrl.shift_base = in_idx;
                                count_next      = count_m1;
                            end else begin
                                status_next = ilst_pkg::STAT_IDX;
                            end
                        end
                        ilst_pkg::REQ_ERASE_RNG: begin
                            if ((in_idx <= in_end) && ({1'b0, in_end} < count_reg)) begin
                                // First move happens now; the rest run in the
                                // shift state, one position per cycle.
                                ctrl.shift_en   = 1'b1;
                                ctrl.shift_base = in_idx;
                                count_next      = count_m1;
                                base_next       = in_idx;
                                remain_next     = in_end - in_idx;
                                if (in_end != in_idx) begin
                                    m_valid_next = 1'b0;
                                    state_next   = ilst_pkg::ST_SHIFT;
                                end
                            end else begin
                                status_next = ilst_pkg::STAT_IDX;
                            end
                        end
                        ilst_pkg::REQ_POP: begin
                            if (count_reg != '0) begin
                                rd_next    = VW'($signed(rd_word));
                                count_next = count_m1;
                            end else begin
                                status_next = ilst_pkg::STAT_IDX;
                            end
                        end
                        default: begin
                            status_next = ilst_pkg::STAT_IDX;
                        end
                    endcase
                    out_cnt_next = count_next;
                end
            end
            ilst_pkg::ST_SHIFT: begin
                ctrl.shift_en   = 1'b1;
                ctrl.shift_base = base_reg;
                count_next      = count_m1;
                remain_next     = remain_reg - IW'(1);
                if (remain_reg == IW'(1)) begin
                    m_valid_next = 1'b1;
                    out_cnt_next = count_m1;
                    state_next   = ilst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ilst_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ilst_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        base_reg    <= base_next;
        remain_reg  <= remain_next;
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(ilst_pkg::M_TDATA_W - ilst_pkg::M_USED_W)'(0),
                       out_cnt_reg, status_reg, rd_reg};

endmodule

// ===== design/ilst_cell.sv =====
module ilst_cell (
    input  logic                          aclk,
    input  ilst_pkg::cell_ctrl_t          ctrl_i,
    input  logic [ilst_pkg::IDX_W-1:0]    pos_i,
    input  logic [ilst_pkg::DATA_WIDTH-1:0] up_data_i,
    output logic [ilst_pkg::DATA_WIDTH-1:0] data_o
);

    logic [ilst_pkg::DATA_WIDTH-1:0] data_reg;
    logic [ilst_pkg::DATA_WIDTH-1:0] data_next;

    // A shift at or below this position pulls the upper neighbor's entry down;
    // otherwise a write addressed here replaces the entry.
    always_comb begin
        data_next = data_reg;
        if (ctrl_i.shift_en && (pos_i >= ctrl_i.shift_base)) begin
            data_next = up_data_i;
        end else if (ctrl_i.wr_en && (ctrl_i.wr_idx == pos_i)) begin
            data_next = ctrl_i.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

// ===== design/ilst_checker.sv =====
module ilst_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ilst_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [ilst_pkg::VALUE_W-1:0]  chk_rd;
    logic [ilst_pkg::STATUS_W-1:0] chk_stat;
    logic [ilst_pkg::CNT_W-1:0]    chk_cnt;

    assign chk_rd   = m_tdata[ilst_pkg::M_RD_LO +: ilst_pkg::VALUE_W];
    assign chk_stat = m_tdata[ilst_pkg::M_STAT_LO +: ilst_pkg::STATUS_W];
    assign chk_cnt  = m_tdata[ilst_pkg::M_CNT_LO +: ilst_pkg::CNT_W];

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A rejected request returns a zero read value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_stat != ilst_pkg::STAT_OK) |-> chk_rd == '0)
        else $error("rejected request returned data");

    // The count never exceeds capacity, and a full report means a full list.
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chk_cnt <= ilst_pkg::CNT_W'(ilst_pkg::CAPACITY)) &&
                     ((chk_stat != ilst_pkg::STAT_FULL) ||
                      (chk_cnt == ilst_pkg::CNT_W'(ilst_pkg::CAPACITY))))
        else $error("count out of range");

    // No input word is taken while a result is stalled at the output.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("input taken while output stalled");

endmodule

bind indexed_list_store_core ilst_checker u_ilst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
